[sv/mcg_period_analyzer_macros.svh]
// ----------------------------------------------------------------------------
// mcg_period_analyzer_macros.svh
// assertion macros shared by the period analyzer checker
// ----------------------------------------------------------------------------
`ifndef MCG_PERIOD_ANALYZER_MACROS_SVH
`define MCG_PERIOD_ANALYZER_MACROS_SVH

// implication checked every cycle outside reset
`define MCG_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition in this cycle implies property in the next cycle
`define MCG_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

[sv/mcg_pkg.sv]
// ----------------------------------------------------------------------------
// mcg_pkg
// shared types and constants of the generator period analyzer
// ----------------------------------------------------------------------------
package mcg_pkg;

   localparam int HISTORY_DEPTH_DEF = 1024;
   localparam int VALUE_WIDTH_DEF   = 32;

   localparam int FIELD_WIDTH     = 32;
   localparam int COUNT_WIDTH     = 11;
   localparam int STATUS_WIDTH    = 2;
   localparam int CSR_INDEX_WIDTH = 1;

   localparam logic [FIELD_WIDTH-1:0] MULTIPLIER_RESET = 32'd16807;
   localparam logic [FIELD_WIDTH-1:0] MODULUS_RESET    = 32'd2147483647;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_MOD_ZERO = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL     = 2'd2;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MULTIPLIER = 1'b0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS    = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_GEN    = 4'b0010,
      ST_SEARCH = 4'b0100,
      ST_RESP   = 4'b1000
   } state_type;

endpackage

[sv/mcg_period_analyzer.sv]
// ----------------------------------------------------------------------------
// mcg_period_analyzer
// cycle detection for x' = (a * x) mod m started from a requested seed
//
//   channel   direction  handshake            payload
//   req_      in         valid / stall        seed
//   rsp_      out        valid / stall        tail, cycle, distinct, status
//   csr_      in         valid / ready        index, data
//
// each generated value passes through the shared modular multiplier, and
// the search of n stored values makes one ram read each, ending early on a
// match; a zero modulus goes straight to the response without generating;
// req_stall stays high until the response is taken
// synchronous reset; the history needs no clearing, a run only reads
// entries it wrote itself
// ----------------------------------------------------------------------------
module mcg_period_analyzer #(
   parameter int HISTORY_DEPTH = mcg_pkg::HISTORY_DEPTH_DEF,
   parameter int VALUE_WIDTH   = mcg_pkg::VALUE_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [mcg_pkg::FIELD_WIDTH-1:0]      req_seed,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mcg_pkg::COUNT_WIDTH-1:0]      rsp_tail_length,
   output logic [mcg_pkg::COUNT_WIDTH-1:0]      rsp_cycle_length,
   output logic [mcg_pkg::COUNT_WIDTH-1:0]      rsp_distinct_count,
   output logic [mcg_pkg::STATUS_WIDTH-1:0]     rsp_status,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [mcg_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [mcg_pkg::FIELD_WIDTH-1:0]      csr_data
);

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int CW = $clog2(HISTORY_DEPTH + 1);
   localparam int W  = VALUE_WIDTH;

   mcg_pkg::state_type state_ff, state_in;

   logic                              first_ff, first_in;
   logic [CW-1:0]                     count_ff, count_in;
   logic [CW-1:0]                     scan_ff, scan_in;
   logic                              chk_vld_ff, chk_vld_in;
   logic [AW-1:0]                     chk_idx_ff, chk_idx_in;
   logic [W-1:0]                      cand_ff, cand_in;
   logic [CW-1:0]                     tail_ff, tail_in;
   logic [CW-1:0]                     cyc_ff, cyc_in;
   logic [CW-1:0]                     dist_ff, dist_in;
   logic [mcg_pkg::STATUS_WIDTH-1:0]  status_ff, status_in;
   logic [W-1:0]                      mult_ff;
   logic [W-1:0]                      mod_ff;

   logic          mm_start;
   logic [W-1:0]  mm_value;
   logic          mm_done;
   logic [W-1:0]  mm_result;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [W-1:0]  wr_data;
   logic [AW-1:0] rd_addr;
   logic [W-1:0]  rd_data;
   logic          hit;
   logic          last;

   mcg_modmul #(
      .VALUE_WIDTH (W)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mm_start),
      .mult    (mult_ff),
      .modulus (mod_ff),
      .value   (mm_value),
      .done    (mm_done),
      .result  (mm_result)
   );

   mcg_hist_ram #(
      .DEPTH (HISTORY_DEPTH),
      .WIDTH (W)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign hit  = chk_vld_ff && (rd_data == cand_ff);
   assign last = chk_vld_ff && (CW'(chk_idx_ff) == count_ff - CW'(1));

   always_comb begin
      state_in   = state_ff;
      first_in   = first_ff;
      count_in   = count_ff;
      scan_in    = scan_ff;
      chk_vld_in = 1'b0;
      chk_idx_in = scan_ff[AW-1:0];
      cand_in    = cand_ff;
      tail_in    = tail_ff;
      cyc_in     = cyc_ff;
      dist_in    = dist_ff;
      status_in  = status_ff;
      mm_start   = 1'b0;
      mm_value   = cand_ff;
      wr_en      = 1'b0;
      wr_addr    = count_ff[AW-1:0];
      wr_data    = mm_result;
      rd_addr    = scan_ff[AW-1:0];
      unique case (state_ff)
         mcg_pkg::ST_IDLE: begin
            if (req_valid) begin
               if (mod_ff == '0) begin
                  tail_in   = '0;
                  cyc_in    = '0;
                  dist_in   = '0;
                  status_in = mcg_pkg::STATUS_MOD_ZERO;
                  state_in  = mcg_pkg::ST_RESP;
               end else begin
                  mm_start = 1'b1;
                  mm_value = req_seed[W-1:0];
                  first_in = 1'b1;
                  count_in = '0;
                  state_in = mcg_pkg::ST_GEN;
               end
            end
         end
         mcg_pkg::ST_GEN: begin
            if (mm_done) begin
               if (first_ff) begin
                  // first value goes straight in, no search
                  wr_en    = 1'b1;
                  wr_data  = mm_result;
                  count_in = CW'(1);
                  first_in = 1'b0;
                  cand_in  = mm_result;
                  mm_start = 1'b1;
                  mm_value = mm_result;
               end else begin
                  cand_in  = mm_result;
                  scan_in  = '0;
                  state_in = mcg_pkg::ST_SEARCH;
               end
            end
         end
         mcg_pkg::ST_SEARCH: begin
            if (scan_ff < count_ff) begin
               chk_vld_in = 1'b1;
               scan_in    = scan_ff + CW'(1);
            end
            if (hit) begin
               chk_vld_in = 1'b0;
               tail_in    = CW'(chk_idx_ff);
               cyc_in     = count_ff - CW'(chk_idx_ff);
               dist_in    = count_ff;
               status_in  = mcg_pkg::STATUS_OK;
               state_in   = mcg_pkg::ST_RESP;
            end else if (last) begin
               chk_vld_in = 1'b0;
               if (count_ff == CW'(HISTORY_DEPTH)) begin
                  tail_in   = CW'(HISTORY_DEPTH);
                  cyc_in    = '0;
                  dist_in   = CW'(HISTORY_DEPTH);
                  status_in = mcg_pkg::STATUS_FULL;
                  state_in  = mcg_pkg::ST_RESP;
               end else begin
                  wr_en    = 1'b1;
                  wr_data  = cand_ff;
                  count_in = count_ff + CW'(1);
                  mm_start = 1'b1;
                  mm_value = cand_ff;
                  state_in = mcg_pkg::ST_GEN;
               end
            end
         end
         mcg_pkg::ST_RESP: begin
            if (!rsp_stall) begin
               state_in = mcg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mcg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= mcg_pkg::ST_IDLE;
         first_ff   <= 1'b0;
         count_ff   <= '0;
         scan_ff    <= '0;
         chk_vld_ff <= 1'b0;
         mult_ff    <= mcg_pkg::MULTIPLIER_RESET[W-1:0];
         mod_ff     <= mcg_pkg::MODULUS_RESET[W-1:0];
      end else begin
         state_ff   <= state_in;
         first_ff   <= first_in;
         count_ff   <= count_in;
         scan_ff    <= scan_in;
         chk_vld_ff <= chk_vld_in;
         if (csr_valid) begin
            unique case (csr_index)
               mcg_pkg::CSR_MULTIPLIER: mult_ff <= csr_data[W-1:0];
               mcg_pkg::CSR_MODULUS:    mod_ff  <= csr_data[W-1:0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      chk_idx_ff <= chk_idx_in;
      cand_ff    <= cand_in;
      tail_ff    <= tail_in;
      cyc_ff     <= cyc_in;
      dist_ff    <= dist_in;
      status_ff  <= status_in;
   end

   assign req_stall          = (state_ff != mcg_pkg::ST_IDLE);
   assign rsp_valid          = (state_ff == mcg_pkg::ST_RESP);
   assign rsp_tail_length    = mcg_pkg::COUNT_WIDTH'(tail_ff);
   assign rsp_cycle_length   = mcg_pkg::COUNT_WIDTH'(cyc_ff);
   assign rsp_distinct_count = mcg_pkg::COUNT_WIDTH'(dist_ff);
   assign rsp_status         = status_ff;
   assign csr_ready          = 1'b1;

endmodule

[sv/mcg_modmul.sv]
// ----------------------------------------------------------------------------
// mcg_modmul
// modular multiply: one registered product, then bit-serial restoring reduction
// ----------------------------------------------------------------------------
module mcg_modmul #(
   parameter int VALUE_WIDTH = mcg_pkg::VALUE_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] mult,
   input  logic [VALUE_WIDTH-1:0] modulus,
   input  logic [VALUE_WIDTH-1:0] value,
   output logic                   done,
   output logic [VALUE_WIDTH-1:0] result
);

   localparam int PW = 2 * VALUE_WIDTH;
   localparam int SW = $clog2(PW + 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [SW-1:0]          cnt_ff, cnt_in;
   logic [PW-1:0]          prod_ff, prod_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH:0]   diff;

   assign trial = {rem_ff, prod_ff[PW-1]};
   assign diff  = trial - {1'b0, modulus};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         prod_in = PW'(mult) * PW'(value);
         rem_in  = '0;
      end else if (busy_ff) begin
         rem_in  = (trial >= {1'b0, modulus}) ? diff[VALUE_WIDTH-1:0]
                                              : trial[VALUE_WIDTH-1:0];
         prod_in = prod_ff << 1;
         cnt_in  = cnt_ff + SW'(1);
         if (cnt_ff == SW'(PW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign done   = done_ff;
   assign result = rem_ff;

endmodule

[sv/mcg_hist_ram.sv]
// ----------------------------------------------------------------------------
// mcg_hist_ram
// history store: one write port, one registered read port
// ----------------------------------------------------------------------------
module mcg_hist_ram #(
   parameter int DEPTH = mcg_pkg::HISTORY_DEPTH_DEF,
   parameter int WIDTH = mcg_pkg::VALUE_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/mcg_checker.sv]
// ----------------------------------------------------------------------------
// mcg_checker
// port-level checks on the period analyzer, bound to the top level
// ----------------------------------------------------------------------------
`include "mcg_period_analyzer_macros.svh"

module mcg_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [mcg_pkg::COUNT_WIDTH-1:0]      rsp_tail_length,
   input logic [mcg_pkg::COUNT_WIDTH-1:0]      rsp_cycle_length,
   input logic [mcg_pkg::COUNT_WIDTH-1:0]      rsp_distinct_count,
   input logic [mcg_pkg::STATUS_WIDTH-1:0]     rsp_status
);

   logic                            rsp_ok;
   logic                            rsp_err;
   logic [mcg_pkg::COUNT_WIDTH-1:0] count_sum;
   logic                            sum_match;
   logic                            no_cycle;
   logic                            rsp_taken;

   assign rsp_ok    = rsp_valid && (rsp_status == mcg_pkg::STATUS_OK);
   assign rsp_err   = rsp_valid && (rsp_status != mcg_pkg::STATUS_OK);
   assign count_sum = rsp_tail_length + rsp_cycle_length;
   assign sum_match = (rsp_distinct_count == count_sum);
   assign no_cycle  = (rsp_cycle_length == '0);
   assign rsp_taken = rsp_valid && !rsp_stall;

   // a pending response keeps new requests out
   `MCG_ASSERT(a_rsp_blocks_req, clock, reset, rsp_valid |-> req_stall, "response with req open")

   // an accepted request closes the input until its response is taken
   `MCG_ASSERT_NEXT(a_req_closes, clock, reset, req_valid && !req_stall, req_stall, "req open")

   // distinct count is tail plus cycle on a good result
   `MCG_ASSERT(a_count_sum, clock, reset, rsp_ok |-> sum_match, "counts inconsistent")

   // no cycle reported on an error status
   `MCG_ASSERT(a_err_no_cycle, clock, reset, rsp_err |-> no_cycle, "cycle on error")

   // a taken response frees the input on the next cycle
   `MCG_ASSERT_NEXT(a_rsp_frees, clock, reset, rsp_taken, !req_stall, "req still closed")

endmodule

bind mcg_period_analyzer mcg_checker u_mcg_checker (.*);
